@@ sv/pnp_pkg.sv @@
// Shared types and constants for the pitch notation parser.
// Holds the item structs, the character class struct and the code points.
// No dependencies.
`default_nettype none

package pnp_pkg;

   // Default limits, handed to the top level as parameter defaults.
   localparam int ALTER_LIMIT_DEFAULT  = 255;
   localparam int OCTAVE_LIMIT_DEFAULT = 63;

   // Fixed numbers of the note formula.
   localparam int SEMIS_PER_OCTAVE = 12;
   localparam int NOTE_MAX         = 127;

   // Code points of the accepted characters.
   localparam logic [15:0] CODE_SHARP_SIGN = 16'h266F;
   localparam logic [15:0] CODE_FLAT_SIGN  = 16'h266D;
   localparam logic [15:0] CODE_HASH       = 16'h0023;
   localparam logic [15:0] CODE_MINUS      = 16'h002D;
   localparam logic [15:0] CODE_DIGIT_0    = 16'h0030;
   localparam logic [15:0] CODE_DIGIT_9    = 16'h0039;
   localparam logic [15:0] CODE_UP_A       = 16'h0041;
   localparam logic [15:0] CODE_UP_B       = 16'h0042;
   localparam logic [15:0] CODE_UP_C       = 16'h0043;
   localparam logic [15:0] CODE_UP_D       = 16'h0044;
   localparam logic [15:0] CODE_UP_E       = 16'h0045;
   localparam logic [15:0] CODE_UP_F       = 16'h0046;
   localparam logic [15:0] CODE_UP_G       = 16'h0047;
   localparam logic [15:0] CODE_LO_A       = 16'h0061;
   localparam logic [15:0] CODE_LO_B       = 16'h0062;
   localparam logic [15:0] CODE_LO_C       = 16'h0063;
   localparam logic [15:0] CODE_LO_D       = 16'h0064;
   localparam logic [15:0] CODE_LO_E       = 16'h0065;
   localparam logic [15:0] CODE_LO_F       = 16'h0066;
   localparam logic [15:0] CODE_LO_G       = 16'h0067;

   // One input item: a UTF-16 code unit and the end-of-string marker.
   typedef struct packed {
      logic [15:0] char_code;
      logic        last_char;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [6:0] note_number;
      logic       note_valid;
   } rsp_type;

   // What one character can mean to the grammar.
   typedef struct packed {
      logic       is_letter;
      logic [3:0] chroma;
      logic       is_sharp;
      logic       is_flat;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
   } char_class_type;

endpackage

`default_nettype wire

@@ sv/pnp_char_decode.sv @@
// Character classifier of the pitch notation parser.
// Maps one UTF-16 code unit onto the grammar classes; uses pnp_pkg.
`default_nettype none

module pnp_char_decode (
   input  wire logic [15:0]             char_code,
   output pnp_pkg::char_class_type      char_class
);

   always_comb begin
      char_class           = '0;
      char_class.is_letter = 1'b1;
      unique case (char_code) inside
         pnp_pkg::CODE_UP_C, pnp_pkg::CODE_LO_C: char_class.chroma = 4'd0;
         pnp_pkg::CODE_UP_D, pnp_pkg::CODE_LO_D: char_class.chroma = 4'd2;
         pnp_pkg::CODE_UP_E, pnp_pkg::CODE_LO_E: char_class.chroma = 4'd4;
         pnp_pkg::CODE_UP_F, pnp_pkg::CODE_LO_F: char_class.chroma = 4'd5;
         pnp_pkg::CODE_UP_G, pnp_pkg::CODE_LO_G: char_class.chroma = 4'd7;
         pnp_pkg::CODE_UP_A, pnp_pkg::CODE_LO_A: char_class.chroma = 4'd9;
         pnp_pkg::CODE_UP_B, pnp_pkg::CODE_LO_B: char_class.chroma = 4'd11;
         default:                                char_class.is_letter = 1'b0;
      endcase

      // A lowercase b is both a letter and a flat; the phase picks which.
      char_class.is_sharp = (char_code == pnp_pkg::CODE_HASH) ||
                            (char_code == pnp_pkg::CODE_SHARP_SIGN);
      char_class.is_flat  = (char_code == pnp_pkg::CODE_LO_B) ||
                            (char_code == pnp_pkg::CODE_FLAT_SIGN);
      char_class.is_minus = (char_code == pnp_pkg::CODE_MINUS);
      char_class.is_digit = (char_code >= pnp_pkg::CODE_DIGIT_0) &&
                            (char_code <= pnp_pkg::CODE_DIGIT_9);
      char_class.digit    = char_code[3:0];
   end

endmodule

`default_nettype wire

@@ sv/pnp_note_calc.sv @@
// Note formula of the pitch notation parser: (octave+1)*12 + chroma +
// alteration, with the range check. Uses pnp_pkg.
`default_nettype none

module pnp_note_calc #(
   parameter int ALTER_LIMIT  = pnp_pkg::ALTER_LIMIT_DEFAULT,
   parameter int OCTAVE_LIMIT = pnp_pkg::OCTAVE_LIMIT_DEFAULT
) (
   input  wire logic                                        phase_ok,
   input  wire logic                                        octave_negative,
   input  wire logic [$clog2(OCTAVE_LIMIT+1)-1:0]           octave_magnitude,
   input  wire logic [3:0]                                  letter_chroma,
   input  wire logic signed [$clog2(ALTER_LIMIT+1):0]       alteration,
   output pnp_pkg::rsp_type                                 rsp
);

   localparam int OCT_W   = $clog2(OCTAVE_LIMIT + 1);
   localparam int ALTER_W = $clog2(ALTER_LIMIT + 1) + 1;
   localparam int NOTE_W  = OCT_W + ALTER_W + 6;

   logic signed [NOTE_W-1:0] mag_ext;
   logic signed [NOTE_W-1:0] octave;
   logic signed [NOTE_W-1:0] octave_p1;
   logic signed [NOTE_W-1:0] note;
   logic                     in_range;

   always_comb begin
      mag_ext   = $signed({{(NOTE_W-OCT_W){1'b0}}, octave_magnitude});
      octave    = octave_negative ? -mag_ext : mag_ext;
      octave_p1 = octave + NOTE_W'(1);
      // Times twelve as eight plus four.
      note      = (octave_p1 <<< 3) + (octave_p1 <<< 2)
                + $signed({{(NOTE_W-4){1'b0}}, letter_chroma})
                + NOTE_W'(alteration);
      in_range  = !note[NOTE_W-1] && (note <= $signed(NOTE_W'(pnp_pkg::NOTE_MAX)));

      rsp.note_valid  = phase_ok && in_range;
      rsp.note_number = rsp.note_valid ? note[6:0] : 7'd0;
   end

endmodule

`default_nettype wire

@@ sv/pitch_notation_parser.sv @@
// Top level of the pitch notation parser: scientific pitch strings to MIDI
// note numbers. Depends on pnp_pkg, pnp_char_decode and pnp_note_calc.
//
// Usage. A pitch string arrives on the req_ channel one UTF-16 code unit per
// item, with req_data.last_char set on its final character. Each string ends
// in exactly one item on the rsp_ channel: the note number and a valid flag.
// Characters that are not last produce nothing on the rsp_ side.
//
// Structure. An input register holds the accepted item. From it, the
// character decode and the next parse state are computed combinationally. On the
// last character the final state is captured into a snapshot register and
// the parser returns to the letter phase. The note formula and range check
// run on the snapshot and land in the result register that drives rsp_.
//
// Timing. One item per cycle is accepted in steady state. The result of a
// string passes through the snapshot register into the result register,
// which drives rsp_valid. When the receiver stalls, results wait in the
// snapshot and result registers; characters that are not last keep flowing,
// and a last character is held in the input register only when both are full.
// Reset. A synchronous reset empties all three stages and puts the parser in
// the letter phase with all accumulators at zero.
`default_nettype none

module pitch_notation_parser #(
   parameter int ALTER_LIMIT  = pnp_pkg::ALTER_LIMIT_DEFAULT,
   parameter int OCTAVE_LIMIT = pnp_pkg::OCTAVE_LIMIT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire pnp_pkg::req_type req_data,

   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      pnp_pkg::rsp_type rsp_data
);

   localparam int OCT_W   = $clog2(OCTAVE_LIMIT + 1);
   localparam int ALTER_W = $clog2(ALTER_LIMIT + 1) + 1;
   localparam int MUL_W   = OCT_W + 4;

   // Parse phases, one-hot.
   typedef enum logic [4:0] {
      PH_LETTER = 5'b00001,
      PH_ACCID  = 5'b00010,
      PH_MINUS  = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

   // Input stage.
   logic             in_valid_ff, in_valid_in;
   pnp_pkg::req_type in_data_ff,  in_data_in;

   // Parse state.
   phase_type                 phase_ff,  phase_in;
   logic [3:0]                chroma_ff, chroma_in;
   logic signed [ALTER_W-1:0] alter_ff,  alter_in;
   logic [OCT_W-1:0]          mag_ff,    mag_in;
   logic                      neg_ff,    neg_in;
   logic                      ovf_ff,    ovf_in;

   // Snapshot of the final state of a string.
   logic                      fin_valid_ff,  fin_valid_in;
   logic                      fin_ok_ff,     fin_ok_in;
   logic                      fin_neg_ff,    fin_neg_in;
   logic [OCT_W-1:0]          fin_mag_ff,    fin_mag_in;
   logic [3:0]                fin_chroma_ff, fin_chroma_in;
   logic signed [ALTER_W-1:0] fin_alter_ff,  fin_alter_in;

   // Result stage.
   logic             rsp_valid_ff, rsp_valid_in;
   pnp_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Handshake between the stages.
   logic rsp_free;
   logic fin_free;
   logic process;

   pnp_pkg::char_class_type char_class;
   pnp_pkg::rsp_type        calc_rsp;
   logic [MUL_W-1:0]        digit_acc;

   pnp_char_decode u_char_decode (
      .char_code  (in_data_ff.char_code),
      .char_class (char_class)
   );

   pnp_note_calc #(
      .ALTER_LIMIT  (ALTER_LIMIT),
      .OCTAVE_LIMIT (OCTAVE_LIMIT)
   ) u_note_calc (
      .phase_ok         (fin_ok_ff),
      .octave_negative  (fin_neg_ff),
      .octave_magnitude (fin_mag_ff),
      .letter_chroma    (fin_chroma_ff),
      .alteration       (fin_alter_ff),
      .rsp              (calc_rsp)
   );

   // A stage may load when it is empty or its item leaves in this cycle.
   // Only a last character needs room in the snapshot stage.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign fin_free  = !fin_valid_ff || rsp_free;
   assign process   = in_valid_ff && (!in_data_ff.last_char || fin_free);
   assign req_ready = !in_valid_ff || process;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next octave magnitude after a digit, before saturation at the limit.
   assign digit_acc = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1)
                    + {{(MUL_W-4){1'b0}}, char_class.digit};

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      chroma_in = chroma_ff;
      alter_in  = alter_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;

      unique case (phase_ff) inside
         PH_LETTER: begin
            if (char_class.is_letter) begin
               chroma_in = char_class.chroma;
               phase_in  = PH_ACCID;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_ACCID: begin
            if (char_class.is_sharp) begin
               if (alter_ff >= $signed(ALTER_W'(ALTER_LIMIT))) begin
                  ovf_in = 1'b1;
               end else begin
                  alter_in = alter_ff + ALTER_W'(1);
               end
            end else if (char_class.is_flat) begin
               if (alter_ff <= -$signed(ALTER_W'(ALTER_LIMIT))) begin
                  ovf_in = 1'b1;
               end else begin
                  alter_in = alter_ff - ALTER_W'(1);
               end
            end else if (char_class.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_MINUS;
            end else if (char_class.is_digit) begin
               mag_in   = (digit_acc > MUL_W'(OCTAVE_LIMIT)) ?
                          OCT_W'(OCTAVE_LIMIT) : digit_acc[OCT_W-1:0];
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_MINUS, PH_DIGITS: begin
            if (char_class.is_digit) begin
               mag_in   = (digit_acc > MUL_W'(OCTAVE_LIMIT)) ?
                          OCT_W'(OCTAVE_LIMIT) : digit_acc[OCT_W-1:0];
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // Snapshot of the state as it stands after the last character.
      fin_ok_in     = (phase_in == PH_DIGITS) && !ovf_in;
      fin_neg_in    = neg_in;
      fin_mag_in    = mag_in;
      fin_chroma_in = chroma_in;
      fin_alter_in  = alter_in;

      // The end of a string puts the parser back to its starting state.
      if (in_data_ff.last_char) begin
         phase_in  = PH_LETTER;
         chroma_in = '0;
         alter_in  = '0;
         mag_in    = '0;
         neg_in    = 1'b0;
         ovf_in    = 1'b0;
      end
   end

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (fin_free) begin
         fin_valid_in = process && in_data_ff.last_char;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_free) begin
         rsp_valid_in = fin_valid_ff;
         rsp_data_in  = calc_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LETTER;
         chroma_ff    <= '0;
         alter_ff     <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            phase_ff  <= phase_in;
            chroma_ff <= chroma_in;
            alter_ff  <= alter_in;
            mag_ff    <= mag_in;
            neg_ff    <= neg_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
      if (fin_free) begin
         fin_ok_ff     <= fin_ok_in;
         fin_neg_ff    <= fin_neg_in;
         fin_mag_ff    <= fin_mag_in;
         fin_chroma_ff <= fin_chroma_in;
         fin_alter_ff  <= fin_alter_in;
      end
   end

   // The parser is back in the letter phase after every last character.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      process && in_data_ff.last_char |=> phase_ff == PH_LETTER && alter_ff == '0)
      else $error("parser did not restart after the end of a string");

   // The alteration count never leaves its limits.
   a_alter_bounded: assert property (@(posedge clock) disable iff (reset)
      (alter_ff <= $signed(ALTER_W'(ALTER_LIMIT))) &&
      (alter_ff >= -$signed(ALTER_W'(ALTER_LIMIT))))
      else $error("alteration count out of range");

   // The octave magnitude never passes its saturation limit.
   a_octave_bounded: assert property (@(posedge clock) disable iff (reset)
      mag_ff <= OCT_W'(OCTAVE_LIMIT))
      else $error("octave magnitude above its limit");

   // An invalid result carries note number zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.note_valid |-> rsp_data_ff.note_number == 7'd0)
      else $error("invalid result with a nonzero note number");

   // A character that is not last never fills the snapshot stage.
   a_snapshot_only_on_last: assert property (@(posedge clock) disable iff (reset)
      fin_free && process && !in_data_ff.last_char |=> !fin_valid_ff)
      else $error("snapshot loaded by a character that is not last");

endmodule

`default_nettype wire

@@ tb/pnp_note_checker.sv @@
// Scoreboard for the pitch notation parser: watches both channels, predicts the
// note of every pitch string and compares it with the result the block returns.
// Depends on pnp_pkg for the item structs, the character codes and the limits.
`timescale 1ns / 100ps

module pnp_note_checker #(
   parameter int ALTER_LIMIT  = pnp_pkg::ALTER_LIMIT_DEFAULT,
   parameter int OCTAVE_LIMIT = pnp_pkg::OCTAVE_LIMIT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire pnp_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire pnp_pkg::rsp_type rsp_data,
   output int                    mismatch_count,
   output int                    notes_pending
);

   typedef enum logic [4:0] {
      SCAN_LETTER      = 5'b00001,
      SCAN_ACCIDENTAL  = 5'b00010,
      SCAN_AFTER_MINUS = 5'b00100,
      SCAN_DIGITS      = 5'b01000,
      SCAN_ERROR       = 5'b10000
   } scan_phase_type;

   scan_phase_type scan_phase;
   int             letter_offset;
   int             alter_count;
   int             octave_mag;
   bit             octave_neg;
   bit             alter_overflow;

   pnp_pkg::rsp_type expected_notes[$];

   function automatic int chroma_of_letter(input logic [15:0] code);
      case (code)
         pnp_pkg::CODE_UP_C, pnp_pkg::CODE_LO_C: return 0;
         pnp_pkg::CODE_UP_D, pnp_pkg::CODE_LO_D: return 2;
         pnp_pkg::CODE_UP_E, pnp_pkg::CODE_LO_E: return 4;
         pnp_pkg::CODE_UP_F, pnp_pkg::CODE_LO_F: return 5;
         pnp_pkg::CODE_UP_G, pnp_pkg::CODE_LO_G: return 7;
         pnp_pkg::CODE_UP_A, pnp_pkg::CODE_LO_A: return 9;
         pnp_pkg::CODE_UP_B, pnp_pkg::CODE_LO_B: return 11;
         default: return -1;
      endcase
   endfunction

   function automatic void restart_parse();
      scan_phase     = SCAN_LETTER;
      letter_offset  = 0;
      alter_count    = 0;
      octave_mag     = 0;
      octave_neg     = 1'b0;
      alter_overflow = 1'b0;
   endfunction

   function automatic void take_octave_digit(input logic [15:0] code);
      int value;
      value      = octave_mag * 10 + int'(code - pnp_pkg::CODE_DIGIT_0);
      octave_mag = (value > OCTAVE_LIMIT) ? OCTAVE_LIMIT : value;
      scan_phase = SCAN_DIGITS;
   endfunction

   // Advances the parse by one character. Returns 1 when the character closes
   // a string, with the note the block should report in note.
   function automatic bit parse_char(input pnp_pkg::req_type item,
                                     output pnp_pkg::rsp_type note);
      logic [15:0] code;
      bit          is_digit;
      int          chroma;
      int          octave;
      int          value;
      bit          ok;
      code     = item.char_code;
      is_digit = (code >= pnp_pkg::CODE_DIGIT_0) && (code <= pnp_pkg::CODE_DIGIT_9);
      case (scan_phase)
         SCAN_LETTER: begin
            chroma = chroma_of_letter(code);
            if (chroma < 0) begin
               scan_phase = SCAN_ERROR;
            end else begin
               letter_offset = chroma;
               scan_phase    = SCAN_ACCIDENTAL;
            end
         end
         SCAN_ACCIDENTAL: begin
            if (code == pnp_pkg::CODE_HASH || code == pnp_pkg::CODE_SHARP_SIGN) begin
               if (alter_count >= ALTER_LIMIT) alter_overflow = 1'b1;
               else alter_count++;
            end else if (code == pnp_pkg::CODE_LO_B || code == pnp_pkg::CODE_FLAT_SIGN) begin
               if (alter_count <= -ALTER_LIMIT) alter_overflow = 1'b1;
               else alter_count--;
            end else if (code == pnp_pkg::CODE_MINUS) begin
               octave_neg = 1'b1;
               scan_phase = SCAN_AFTER_MINUS;
            end else if (is_digit) begin
               take_octave_digit(code);
            end else begin
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_AFTER_MINUS, SCAN_DIGITS: begin
            if (is_digit) take_octave_digit(code);
            else scan_phase = SCAN_ERROR;
         end
         default: begin
            scan_phase = SCAN_ERROR;
         end
      endcase

      note = '0;
      if (!item.last_char) return 1'b0;

      ok     = (scan_phase == SCAN_DIGITS) && !alter_overflow;
      octave = octave_neg ? -octave_mag : octave_mag;
      value  = (octave + 1) * pnp_pkg::SEMIS_PER_OCTAVE + letter_offset + alter_count;
      if (value < 0 || value > pnp_pkg::NOTE_MAX) ok = 1'b0;
      if (ok) begin
         note.note_number = value[6:0];
         note.note_valid  = 1'b1;
      end
      restart_parse();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: note check failed: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      pnp_pkg::rsp_type predicted;
      pnp_pkg::rsp_type oldest;
      if (reset) begin
         restart_parse();
         expected_notes.delete();
         mismatch_count = 0;
      end else begin
         // Results leave before the new character is parsed; a string's
         // result can never come back on the edge that takes its last item.
         if (rsp_valid && rsp_ready) begin
            if (expected_notes.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0b with no string pending",
                                         rsp_data.note_number, rsp_data.note_valid));
            end else begin
               oldest = expected_notes.pop_front();
               if (rsp_data.note_number !== oldest.note_number)
                  report_mismatch($sformatf("note_number %0d, expected %0d",
                                            rsp_data.note_number, oldest.note_number));
               if (rsp_data.note_valid !== oldest.note_valid)
                  report_mismatch($sformatf("note_valid %0b, expected %0b",
                                            rsp_data.note_valid, oldest.note_valid));
            end
         end
         if (req_valid && req_ready) begin
            if (parse_char(req_data, predicted)) expected_notes.push_back(predicted);
         end
      end
      notes_pending <= expected_notes.size();
   end

endmodule

@@ tb/tb_pitch_notation_parser.sv @@
// Top of the pitch notation parser testbench: clock, reset, character stimulus
// and the ready pattern of the result side. Checking lives in pnp_note_checker.
// Depends on pnp_pkg, pnp_note_checker and the pitch_notation_parser RTL.
`timescale 1ns / 100ps

module tb_pitch_notation_parser;

   // No new string starts once this many characters have been accepted.
   localparam int TARGET_CHARS     = 1800;
   // The one long stall of the receiver, long enough to back the block up.
   localparam int LONG_HOLD_CYCLES = 400;
   // Bound on the wait for outstanding results after the last character.
   localparam int DRAIN_LIMIT      = 4000;
   // The settle time leaves room beyond the path from a last character to its
   // result for anything unexpected to show up.
   localparam int SETTLE_CYCLES    = 16;
   // Hard stop for the whole run. The slowest legal run (every character
   // behind the longest sender gap, every result behind the longest stall)
   // stays well under a quarter of this.
   localparam int RUN_LIMIT_NS     = 25_000_000;

   // Code points that look like they belong but must be rejected.
   localparam logic [15:0] CODE_ARABIC_DIGIT_0    = 16'h0660;
   localparam logic [15:0] CODE_FULLWIDTH_DIGIT_0 = 16'hFF10;
   localparam logic [15:0] CODE_NATURAL_SIGN      = 16'h266E;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pnp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pnp_pkg::rsp_type rsp_data;

   int      mismatch_count;
   int      notes_pending;

   // Characters of the string being sent, first character at index 0.
   logic [15:0] pitch_chars[$];
   int          chars_sent   = 0;
   // While set, the sender offers items back to back without gaps.
   bit          burst        = 1'b0;
   // Raised once the directed strings are out; the receiver then holds off.
   bit          hold_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pitch_notation_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pnp_note_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .notes_pending  (notes_pending)
   );

   // Sender gaps: mostly none or short, now and then a long one. In a burst
   // stretch there are none at all.
   function automatic int pick_gap();
      int roll;
      if (burst) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] random_letter();
      if ($urandom_range(0, 1) == 1) return pnp_pkg::CODE_UP_A + 16'($urandom_range(0, 6));
      return pnp_pkg::CODE_LO_A + 16'($urandom_range(0, 6));
   endfunction

   function automatic logic [15:0] random_accidental();
      case ($urandom_range(0, 3))
         0: return pnp_pkg::CODE_HASH;
         1: return pnp_pkg::CODE_SHARP_SIGN;
         2: return pnp_pkg::CODE_LO_B;
         default: return pnp_pkg::CODE_FLAT_SIGN;
      endcase
   endfunction

   function automatic logic [15:0] random_digit();
      return pnp_pkg::CODE_DIGIT_0 + 16'($urandom_range(0, 9));
   endfunction

   // Characters that break the grammar, or legal ones that may land in the
   // wrong place. Fully random codes make every bit of the field toggle.
   function automatic logic [15:0] noise_char();
      case ($urandom_range(0, 7))
         0, 1: return 16'($urandom);
         2: return CODE_ARABIC_DIGIT_0 + 16'($urandom_range(0, 9));
         3: return CODE_FULLWIDTH_DIGIT_0 + 16'($urandom_range(0, 9));
         4: return CODE_NATURAL_SIGN;
         5: return random_letter();
         6: return ($urandom_range(0, 1) == 1) ? pnp_pkg::CODE_MINUS : random_accidental();
         default: return pnp_pkg::CODE_UP_A + 16'($urandom_range(7, 25));
      endcase
   endfunction

   // Offers one item and returns at the edge that accepts it. Valid is only
   // lowered for a gap, so back-to-back items keep it high throughout.
   task automatic send_char(input logic [15:0] code, input logic is_last);
      int               gap;
      pnp_pkg::req_type item;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.char_code = code;
      item.last_char = is_last;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_pitch();
      int idx;
      for (idx = 0; idx < pitch_chars.size(); idx++)
         send_char(pitch_chars[idx], idx == pitch_chars.size() - 1);
   endtask

   // Builds one random string. Most are well formed with random content, so
   // that the octave and note range logic is reached; the rest are noise or
   // well formed strings that get damaged, cut short or padded.
   task automatic build_random_pitch(input int string_index);
      int  kind;
      int  count;
      int  pos;
      bit  sharp_run;
      pitch_chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         count = $urandom_range(1, 5);
         repeat (count) pitch_chars.push_back(noise_char());
      end else begin
         pitch_chars.push_back(random_letter());
         // A few strings carry a run of accidentals past the counter limit, the runs
         // alternating between upward and downward.
         if (string_index % 160 == 80) begin
            sharp_run = ((string_index / 160) % 2) == 0;
            count     = $urandom_range(pnp_pkg::ALTER_LIMIT_DEFAULT + 1,
                                       pnp_pkg::ALTER_LIMIT_DEFAULT + 3);
            repeat (count) begin
               if (sharp_run)
                  pitch_chars.push_back(($urandom_range(0, 1) == 1)
                                        ? pnp_pkg::CODE_HASH : pnp_pkg::CODE_SHARP_SIGN);
               else
                  pitch_chars.push_back(($urandom_range(0, 1) == 1)
                                        ? pnp_pkg::CODE_LO_B : pnp_pkg::CODE_FLAT_SIGN);
            end
         end else begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 10)
                                                : $urandom_range(0, 2);
            repeat (count) pitch_chars.push_back(random_accidental());
         end
         if ($urandom_range(0, 3) == 0) pitch_chars.push_back(pnp_pkg::CODE_MINUS);
         // Mostly one octave digit; longer ones hit leading zeros and the
         // saturation of the octave.
         pos = $urandom_range(0, 19);
         count = (pos < 15) ? 1 : (pos < 19) ? 2 : $urandom_range(3, 4);
         repeat (count) pitch_chars.push_back(random_digit());

         if (kind >= 75) begin
            case ($urandom_range(0, 2))
               0: begin
                  pos = $urandom_range(0, pitch_chars.size() - 1);
                  pitch_chars[pos] = noise_char();
               end
               1: begin
                  // Cut the octave off so the string ends early.
                  while (pitch_chars.size() > 1
                         && pitch_chars[$] >= pnp_pkg::CODE_DIGIT_0
                         && pitch_chars[$] <= pnp_pkg::CODE_DIGIT_9)
                     void'(pitch_chars.pop_back());
               end
               default: begin
                  pos = $urandom_range(0, pitch_chars.size());
                  pitch_chars.insert(pos, noise_char());
               end
            endcase
         end
      end
   endtask

   // Result side. Apart from the one long hold-off, ready follows a random
   // pattern: short stretches of ready and short stalls, now and then a long one.
   initial begin : receiver
      int roll;
      int span;
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            roll = $urandom_range(0, 19);
            if (roll < 10) begin
               rsp_ready <= 1'b1;
               span = $urandom_range(1, 20);
            end else if (roll == 10) begin
               rsp_ready <= 1'b1;
               span = $urandom_range(50, 200);
            end else if (roll < 17) begin
               rsp_ready <= 1'b0;
               span = $urandom_range(1, 3);
            end else if (roll < 19) begin
               rsp_ready <= 1'b0;
               span = $urandom_range(4, 12);
            end else begin
               rsp_ready <= 1'b0;
               span = $urandom_range(20, 60);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int string_index;
      int drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed strings. Lowest and highest valid notes first.
      pitch_chars = '{pnp_pkg::CODE_UP_C, pnp_pkg::CODE_MINUS, pnp_pkg::CODE_DIGIT_0 + 16'd1};
      send_pitch();
      pitch_chars = '{pnp_pkg::CODE_UP_G, pnp_pkg::CODE_DIGIT_9};
      send_pitch();
      // One semitone past each end of the note range.
      pitch_chars = '{pnp_pkg::CODE_LO_G, pnp_pkg::CODE_HASH, pnp_pkg::CODE_DIGIT_9};
      send_pitch();
      pitch_chars = '{pnp_pkg::CODE_UP_C, pnp_pkg::CODE_LO_B, pnp_pkg::CODE_MINUS,
                      pnp_pkg::CODE_DIGIT_0 + 16'd1};
      send_pitch();
      // The Unicode sharp and flat signs.
      pitch_chars = '{pnp_pkg::CODE_LO_E, pnp_pkg::CODE_SHARP_SIGN, pnp_pkg::CODE_DIGIT_0};
      send_pitch();
      pitch_chars = '{pnp_pkg::CODE_UP_B, pnp_pkg::CODE_FLAT_SIGN,
                      pnp_pkg::CODE_DIGIT_0 + 16'd3};
      send_pitch();
      // Malformed from the first character, using both extremes of the code.
      pitch_chars = '{16'hFFFF, 16'h0000};
      send_pitch();
      // Strings that stop before any octave digit.
      pitch_chars = '{pnp_pkg::CODE_UP_D, pnp_pkg::CODE_HASH};
      send_pitch();
      pitch_chars = '{pnp_pkg::CODE_LO_F, pnp_pkg::CODE_MINUS};
      send_pitch();
      // A long octave that saturates.
      pitch_chars = '{pnp_pkg::CODE_UP_A, pnp_pkg::CODE_DIGIT_9, pnp_pkg::CODE_DIGIT_9};
      send_pitch();

      // Random strings. The receiver's long hold-off starts now, while the
      // sender keeps offering characters.
      hold_request <= 1'b1;
      string_index = 0;
      while (chars_sent < TARGET_CHARS) begin
         if ($urandom_range(0, 24) == 0) burst = !burst;
         build_random_pitch(string_index);
         send_pitch();
         string_index++;
      end
      req_valid <= 1'b0;

      // The checker's pending count is registered, so step past an edge before
      // looking at it, then wait for the last results.
      @(posedge clock);
      drain = 0;
      while (notes_pending != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && notes_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
